[rtl/dgr_pkg.sv]
// Shared codes and field widths for the directed graph reachability unit.
package dgr_pkg;

  localparam int OP_W = 2;
  localparam int ID_W = 6;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_EXISTS  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  localparam logic [ID_W-1:0] NUM_NODES_RESET = 6'd10;

  typedef struct packed {
    logic            reachable;
    logic [ST_W-1:0] status;
  } result_t;

endpackage

[rtl/directed_graph_reachability_unit.sv]
// Directed graph reachability unit: adjacency-matrix memory with edit and query sequencer.
// Clear and out-of-range beats go straight to the finishing state, insert/delete pass
// through a read-modify-write step, and a query walks the graph one expanded node per read.
// One item at a time; a query is paced by the single read port of the adjacency memory,
// which returns one row per cycle. A new beat is taken while the last result waits.
// Reset (synchronous, rst_n low) empties the graph at once through per-row valid flags,
// with no clearing pass, and sets num_nodes to 10.
module directed_graph_reachability_unit
  import dgr_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: num_nodes
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  // input stream, tdata from bit 0: opcode[1:0], source_node[7:2], dest_node[13:8]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // result stream, tdata from bit 0: status[1:0], reachable[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef logic [MAX_NODES-1:0] row_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EDIT = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // input beat fields
  logic [OP_W-1:0] in_opcode;
  logic [ID_W-1:0] in_source_node;
  logic [ID_W-1:0] in_dest_node;

  assign in_opcode      = in_tdata[1:0];
  assign in_source_node = in_tdata[7:2];
  assign in_dest_node   = in_tdata[13:8];

  // registers
  logic [1:0]      state_r,     state_nxt;
  logic [ID_W-1:0] num_nodes_r;
  row_t            row_ok_r,    row_ok_nxt;
  row_t            pending_r,   pending_nxt;
  row_t            visited_r,   visited_nxt;
  logic            rd_busy_r,   rd_busy_nxt;
  logic [OP_W-1:0] op_r,        op_nxt;
  idx_t            si_r,        si_nxt;
  idx_t            di_r,        di_nxt;
  result_t         res_r,       res_nxt;
  logic            out_tvalid_r;
  result_t         out_res_r;

  // adjacency memory: one row per source node
  row_t adj_mem [MAX_NODES];
  row_t rd_data_r;
  logic rd_ok_r;
  logic mem_re, mem_we;
  idx_t mem_raddr, mem_waddr;
  row_t mem_wdata;

  logic    accept;
  logic    src_ok, dst_ok;
  row_t    node_mask;
  row_t    rd_row, row_eff, new_nodes, pend_all;
  idx_t    pick;
  logic    out_load;

  function automatic idx_t first_set(input row_t v);
    idx_t idx;
    idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // ids run from 1 to min(num_nodes, MAX_NODES)
  assign src_ok = (in_source_node != '0) && (in_source_node <= num_nodes_r) &&
                  (32'(in_source_node) <= MAX_NODES);
  assign dst_ok = (in_dest_node != '0) && (in_dest_node <= num_nodes_r) &&
                  (32'(in_dest_node) <= MAX_NODES);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      node_mask[i] = (32'(i) < 32'(num_nodes_r));
    end
  end

  // a row never written since reset or clear reads as empty
  assign rd_row    = rd_ok_r ? rd_data_r : '0;
  assign row_eff   = rd_busy_r ? rd_row : '0;
  assign new_nodes = row_eff & node_mask & ~visited_r;
  assign pend_all  = pending_r | new_nodes;
  assign pick      = first_set(pend_all);

  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    row_ok_nxt  = row_ok_r;
    pending_nxt = pending_r;
    visited_nxt = visited_r;
    rd_busy_nxt = 1'b0;
    op_nxt      = op_r;
    si_nxt      = si_r;
    di_nxt      = di_r;
    res_nxt     = res_r;
    mem_re      = 1'b0;
    mem_raddr   = si_r;
    mem_we      = 1'b0;
    mem_waddr   = si_r;
    mem_wdata   = rd_row;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_opcode;
          si_nxt = IDX_W'(in_source_node - 6'd1);
          di_nxt = IDX_W'(in_dest_node - 6'd1);
          res_nxt.reachable = 1'b0;
          res_nxt.status    = ST_OK;
          if (in_opcode == OP_CLEAR) begin
            // drop every row at once
            row_ok_nxt = '0;
            state_nxt  = S_DONE;
          end else if (!src_ok || !dst_ok) begin
            res_nxt.status = ST_RANGE;
            state_nxt      = S_DONE;
          end else if (in_opcode == OP_QUERY) begin
            // source goes on the worklist unmarked
            pending_nxt = row_t'(1) << IDX_W'(in_source_node - 6'd1);
            visited_nxt = '0;
            state_nxt   = S_WALK;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(in_source_node - 6'd1);
            state_nxt = S_EDIT;
          end
        end
      end

      S_EDIT: begin
        // read-modify-write of the source row
        if (op_r == OP_INSERT) begin
          if (rd_row[di_r]) begin
            res_nxt.status = ST_EXISTS;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rd_row | (row_t'(1) << di_r);
          end
        end else begin
          if (!rd_row[di_r]) begin
            res_nxt.status = ST_MISSING;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = rd_row & ~(row_t'(1) << di_r);
          end
        end
        if (mem_we) row_ok_nxt[si_r] = 1'b1;
        state_nxt = S_DONE;
      end

      S_WALK: begin
        if (rd_busy_r && row_eff[di_r]) begin
          res_nxt.reachable = 1'b1;
          state_nxt         = S_DONE;
        end else if (pend_all != '0) begin
          // expand the lowest pending node, mark what the last row found
          mem_re      = 1'b1;
          mem_raddr   = pick;
          rd_busy_nxt = 1'b1;
          pending_nxt = pend_all & ~(row_t'(1) << pick);
          visited_nxt = visited_r | new_nodes;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) adj_mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rd_data_r <= adj_mem[mem_raddr];
      rd_ok_r   <= row_ok_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_nodes_r  <= NUM_NODES_RESET;
      row_ok_r     <= '0;
      rd_busy_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_ok_r  <= row_ok_nxt;
      rd_busy_r <= rd_busy_nxt;
      if (cfg_wr_en) num_nodes_r <= cfg_wr_data;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pending_r <= pending_nxt;
    visited_r <= visited_nxt;
    op_r      <= op_nxt;
    si_r      <= si_nxt;
    di_r      <= di_nxt;
    res_r     <= res_nxt;
    if (out_load) out_res_r <= res_r;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_res_r.reachable, out_res_r.status};

  // a new result beat only comes out of the finishing state
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the finishing state");

  // an edit cycle always follows an accepted beat
  a_edit_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIT) |-> $past(accept))
    else $error("edit step without an accepted beat");

  // a clear leaves no valid row behind
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_CLEAR) |=> (row_ok_r == '0))
    else $error("rows still valid after clear");

  // a row read is only outstanding while walking
  a_read_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    rd_busy_r |-> (state_r == S_WALK))
    else $error("walk read outstanding outside a query");

endmodule
